### rtl/ccinv_pkg.sv
// ----------------------------------------------------------------------------
// ccinv_pkg
// shared types, constants and the denomination table of the change maker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ccinv_pkg;

    localparam int NUM_DENOM       = 9;
    localparam int CNT_W           = 10;  // coin counts, stock, amounts
    localparam int BEST_W          = 11;  // best count holds amount + 1
    localparam int IDX_W           = 4;
    localparam int MAX_AMOUNT_DEF  = 1023;
    localparam int STOCK_MAX_DEF   = 1023;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_CHANGE = 1'b1;
    localparam logic MODE_GREEDY = 1'b0;

    typedef struct packed {
        logic [BEST_W-1:0]               best;
        logic [NUM_DENOM-1:0][CNT_W-1:0] cnt;
    } ccinv_row_t;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_GREEDY = 8'b0000_0010,
        ST_INIT   = 8'b0000_0100,
        ST_PASS   = 8'b0000_1000,
        ST_RD     = 8'b0001_0000,
        ST_WR     = 8'b0010_0000,
        ST_FIN_RD = 8'b0100_0000,
        ST_FIN    = 8'b1000_0000
    } ccinv_state_t;

    function automatic logic [CNT_W-1:0] denom_val(input logic [IDX_W-1:0] idx);
        logic [CNT_W-1:0] d;
        unique case (idx)
            4'd0:    d = 10'd1;
            4'd1:    d = 10'd2;
            4'd2:    d = 10'd5;
            4'd3:    d = 10'd10;
            4'd4:    d = 10'd20;
            4'd5:    d = 10'd50;
            4'd6:    d = 10'd100;
            4'd7:    d = 10'd200;
            4'd8:    d = 10'd500;
            default: d = 10'd1;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

### rtl/ccinv_tbl_mem.sv
// ----------------------------------------------------------------------------
// ccinv_tbl_mem
// dp table: one write port, two registered read ports
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ccinv_tbl_mem #(
    parameter int DEPTH = 1024
) (
    input  wire                          clk,
    input  wire                          we,
    input  wire  [$clog2(DEPTH)-1:0]     waddr,
    input  ccinv_pkg::ccinv_row_t        wdata,
    input  wire  [$clog2(DEPTH)-1:0]     raddr_a,
    input  wire  [$clog2(DEPTH)-1:0]     raddr_b,
    output ccinv_pkg::ccinv_row_t        rdata_a,
    output ccinv_pkg::ccinv_row_t        rdata_b
);
    import ccinv_pkg::*;

    ccinv_row_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

### rtl/coin_change_with_inventory_top.sv
// ----------------------------------------------------------------------------
// coin_change_with_inventory_top
// change maker with coin stock, greedy or minimum-coin dynamic program
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its one result shows
// for a single cycle with done high and cannot be held off by the receiver.
// A load item is answered in the cycle after it is taken and busy stays low.
// A change item holds busy high: greedy mode walks one coin per cycle, largest
// denomination first, stepping down when a coin does not fit or is out of stock, then delivers.
// Dynamic mode first initialises the table rows from zero up to the amount, then
// picks in turn each denomination d in stock that fits the amount and, for
// every amount from d up to the amount, reads the table (ST_RD, a registered
// read) and then writes it (ST_WR); ST_FIN_RD and ST_FIN read the answer row
// and check it against the stock before the result is delivered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module coin_change_with_inventory_top #(
    parameter int MAX_AMOUNT = ccinv_pkg::MAX_AMOUNT_DEF,
    parameter int STOCK_MAX  = ccinv_pkg::STOCK_MAX_DEF
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  start,
    output logic                                 busy,
    input  wire                                  cmd,
    input  wire  [ccinv_pkg::IDX_W-1:0]          denom_index,
    input  wire  [ccinv_pkg::CNT_W-1:0]          value,
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire                                  cfg_data,
    output logic                                 done,
    output logic [ccinv_pkg::CNT_W-1:0]          coins_of_1,
    output logic [ccinv_pkg::CNT_W-1:0]          coins_of_2,
    output logic [ccinv_pkg::CNT_W-1:0]          coins_of_5,
    output logic [ccinv_pkg::CNT_W-1:0]          coins_of_10,
    output logic [ccinv_pkg::CNT_W-1:0]          coins_of_20,
    output logic [ccinv_pkg::CNT_W-1:0]          coins_of_50,
    output logic [ccinv_pkg::CNT_W-1:0]          coins_of_100,
    output logic [ccinv_pkg::CNT_W-1:0]          coins_of_200,
    output logic [ccinv_pkg::CNT_W-1:0]          coins_of_500,
    output logic                                 valid_res
);
    import ccinv_pkg::*;

    // table covers only amounts the value port can carry
    localparam int DEPTH = ((MAX_AMOUNT < 1023) ? MAX_AMOUNT : 1023) + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [16:0] MAX_LIM   = 17'(MAX_AMOUNT);
    localparam logic [16:0] STOCK_LIM = 17'(STOCK_MAX);

    ccinv_state_t                    state_reg, state_next;
    logic                            mode_reg;
    logic [NUM_DENOM-1:0][CNT_W-1:0] stock_reg, stock_next;
    logic [NUM_DENOM-1:0][CNT_W-1:0] give_reg, give_next;
    logic [NUM_DENOM-1:0][CNT_W-1:0] out_reg, out_next;
    logic                            valid_reg, valid_next;
    logic                            done_reg, done_next;
    logic                            ok_reg, ok_next;
    logic                            fin_reg, fin_next;   // result pending this cycle
    logic [CNT_W-1:0]                amount_reg, amount_next;
    logic [CNT_W-1:0]                rest_reg, rest_next;
    logic [CNT_W-1:0]                j_reg, j_next;
    logic [IDX_W-1:0]                di_reg, di_next;

    // table port signals
    logic                            tbl_we;
    logic [AW-1:0]                   tbl_waddr, tbl_raddr_a, tbl_raddr_b;
    ccinv_row_t                      tbl_wdata, row_a, row_b;

    // denomination value shared by both modes, and the dp offset j - d
    logic [CNT_W-1:0]                d_cur;
    logic [CNT_W-1:0]                j_minus_d;
    logic                            all_fit;

    assign d_cur     = denom_val(di_reg);
    assign j_minus_d = j_reg - d_cur;

    ccinv_tbl_mem #(
        .DEPTH (DEPTH)
    ) u_tbl (
        .clk     (clk),
        .we      (tbl_we),
        .waddr   (tbl_waddr),
        .wdata   (tbl_wdata),
        .raddr_a (tbl_raddr_a),
        .raddr_b (tbl_raddr_b),
        .rdata_a (row_a),
        .rdata_b (row_b)
    );

    // read a: predecessor row in a pass, the answer row at the end
    assign tbl_raddr_a = (state_reg == ST_FIN_RD) ? amount_reg[AW-1:0] : j_minus_d[AW-1:0];
    assign tbl_raddr_b = j_reg[AW-1:0];
    assign tbl_waddr   = j_reg[AW-1:0];

    always_comb
    begin
        all_fit = 1'b1;
        for (int k = 0; k < NUM_DENOM; k++)
        begin
            if (row_a.cnt[k] > stock_reg[k])
            begin
                all_fit = 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        stock_next  = stock_reg;
        give_next   = give_reg;
        out_next    = out_reg;
        valid_next  = valid_reg;
        done_next   = 1'b0;
        ok_next     = ok_reg;
        fin_next    = 1'b0;
        amount_next = amount_reg;
        rest_next   = rest_reg;
        j_next      = j_reg;
        di_next     = di_reg;
        tbl_we      = 1'b0;
        tbl_wdata   = row_a;

        // deliver a finished change item, deducting on success
        if (fin_reg)
        begin
            done_next  = 1'b1;
            valid_next = ok_reg;
            for (int k = 0; k < NUM_DENOM; k++)
            begin
                out_next[k] = ok_reg ? give_reg[k] : '0;
                if (ok_reg)
                begin
                    stock_next[k] = stock_reg[k] - give_reg[k];
                end
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && !fin_reg)
                begin
                    give_next   = '0;
                    amount_next = value;
                    rest_next   = value;
                    if (cmd == CMD_LOAD)
                    begin
                        done_next  = 1'b1;
                        out_next   = '0;
                        valid_next = (denom_index < IDX_W'(NUM_DENOM));
                        if (denom_index < IDX_W'(NUM_DENOM))
                        begin
                            stock_next[denom_index] = ({7'b0, value} > STOCK_LIM) ?
                                                      STOCK_LIM[CNT_W-1:0] : value;
                        end
                    end
                    else if ({7'b0, value} > MAX_LIM)
                    begin
                        ok_next  = 1'b0;
                        fin_next = 1'b1;
                    end
                    else if (mode_reg == MODE_GREEDY)
                    begin
                        di_next    = IDX_W'(NUM_DENOM - 1);
                        state_next = ST_GREEDY;
                    end
                    else
                    begin
                        j_next     = '0;
                        state_next = ST_INIT;
                    end
                end
            end

            // one coin per cycle while the current denomination fits and is in stock, largest denomination first
            ST_GREEDY:
            begin
                if (rest_reg >= d_cur && give_reg[di_reg] < stock_reg[di_reg])
                begin
                    rest_next          = rest_reg - d_cur;
                    give_next[di_reg]  = give_reg[di_reg] + 1'b1;
                end
                else if (di_reg == '0)
                begin
                    ok_next    = (rest_reg == '0);
                    fin_next   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    di_next = di_reg - 1'b1;
                end
            end

            // row 0 is zero coins, other rows start out of reach
            ST_INIT:
            begin
                tbl_we         = 1'b1;
                tbl_wdata.cnt  = '0;
                tbl_wdata.best = (j_reg == '0) ? '0 : ({1'b0, amount_reg} + 1'b1);
                if (j_reg == amount_reg)
                begin
                    di_next    = '0;
                    state_next = ST_PASS;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end

            // pick the next denomination in stock that fits the amount
            ST_PASS:
            begin
                if (di_reg == IDX_W'(NUM_DENOM))
                begin
                    state_next = ST_FIN_RD;
                end
                else if (stock_reg[di_reg] != '0 && d_cur <= amount_reg)
                begin
                    j_next     = d_cur;
                    state_next = ST_RD;
                end
                else
                begin
                    di_next = di_reg + 1'b1;
                end
            end

            ST_RD:
            begin
                state_next = ST_WR;
            end

            // strict improvement only, so earlier denominations win ties
            ST_WR:
            begin
                if ((row_a.best + 1'b1) < row_b.best)
                begin
                    tbl_we                = 1'b1;
                    tbl_wdata.best        = row_a.best + 1'b1;
                    tbl_wdata.cnt[di_reg] = row_a.cnt[di_reg] + 1'b1;
                end
                if (j_reg == amount_reg)
                begin
                    di_next    = di_reg + 1'b1;
                    state_next = ST_PASS;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_RD;
                end
            end

            ST_FIN_RD:
            begin
                state_next = ST_FIN;
            end

            ST_FIN:
            begin
                ok_next    = (row_a.best <= {1'b0, amount_reg}) && all_fit;
                give_next  = row_a.cnt;
                fin_next   = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg  <= 1'b0;
            stock_reg <= '0;
            done_reg  <= 1'b0;
            fin_reg   <= 1'b0;
            valid_reg <= 1'b0;
            out_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            stock_reg <= stock_next;
            done_reg  <= done_next;
            fin_reg   <= fin_next;
            valid_reg <= valid_next;
            out_reg   <= out_next;
            if (cfg_valid && cfg_ready)
            begin
                mode_reg <= cfg_data;
            end
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        give_reg   <= give_next;
        ok_reg     <= ok_next;
        amount_reg <= amount_next;
        rest_reg   <= rest_next;
        j_reg      <= j_next;
        di_reg     <= di_next;
    end

    // busy covers the cycle that delivers a change result
    assign busy      = (state_reg != ST_IDLE) || fin_reg;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign valid_res = valid_reg;

    assign coins_of_1   = out_reg[0];
    assign coins_of_2   = out_reg[1];
    assign coins_of_5   = out_reg[2];
    assign coins_of_10  = out_reg[3];
    assign coins_of_20  = out_reg[4];
    assign coins_of_50  = out_reg[5];
    assign coins_of_100 = out_reg[6];
    assign coins_of_200 = out_reg[7];
    assign coins_of_500 = out_reg[8];

`ifndef ASSERT_OFF
    // a load answers next cycle, a change item keeps the block busy
    a_accept_answers: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("accepted item neither answered nor in progress");

    // a failed result carries no coins
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !valid_res) |-> (out_reg == '0))
        else $error("failed result carries coins");

    // a pending finish is always delivered as a change result
    a_fin_done: assert property (@(posedge clk) disable iff (!rst_n)
        fin_reg |=> done)
        else $error("finished change item not delivered");
`endif

endmodule

`default_nettype wire
